// ----- hw/rtl/pfn_pkg.sv -----
// shared constants, tables and arithmetic helpers for the fbm noise pixel block
// no dependencies; used by pfn_octave, perlin_fbm_noise_pixel and its checker

package pfn_pkg;

    // octave limits and register defaults
    localparam int          MAX_OCTAVES_DEF   = 16;
    localparam int          OCT_CNT_W         = 5;
    localparam logic [4:0]  OCT_CNT_RESET     = 5'd16;
    localparam logic [0:0]  REG_OCTAVE_COUNT  = 1'b0;

    // scale 0.001 as a 2^-40 fixed-point factor
    localparam int          COORD_K_W         = 31;
    localparam logic [30:0] COORD_K           = 31'd1099511628;

    // coordinate word: 8 cell bits over 40 fraction bits
    localparam int          COORD_W           = 48;
    localparam int          ACC_W             = 48;
    localparam int          NOISE_W           = 20;
    localparam int          FADE_W            = 17;

    // octave unit latency and overall pipeline depth ahead of the output register
    localparam int          OCT_LAT           = 6;
    localparam int          PIPE_DEPTH        = OCT_LAT + 4;

    // fade polynomial constants in q24
    localparam logic [27:0] FADE_C15          = 28'd251658240;
    localparam logic [27:0] FADE_C10          = 28'd167772160;
    localparam logic signed [17:0] ONE_Q16    = 18'sd65536;

    // permutation table
    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // gradient dot product with the z component dropped
    function automatic logic signed [19:0] grad2(
        input logic [3:0]         h,
        input logic signed [17:0] x,
        input logic signed [17:0] y
    );
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic signed [19:0] su;
        logic signed [19:0] sv;
        u  = (h < 4'd8) ? 20'(x) : 20'(y);
        if (h < 4'd4)
            v = 20'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = 20'(x);
        else
            v = '0;
        su = h[0] ? -u : u;
        sv = h[1] ? -v : v;
        return su + sv;
    endfunction

    // a + floor((b - a) * t / 2^16), t in q1.16 up to one
    function automatic logic signed [19:0] lerp_q16(
        input logic [16:0]        t,
        input logic signed [19:0] a,
        input logic signed [19:0] b
    );
        logic signed [20:0] d;
        logic signed [38:0] p;
        logic signed [22:0] r;
        d = 21'(b) - 21'(a);
        p = 39'(d) * 39'($signed({1'b0, t}));
        r = p[38:16];
        return 20'(23'(a) + r);
    endfunction

endpackage

// ----- hw/rtl/pfn_octave.sv -----
// one noise octave: fade, hash and lerp pipeline for a fixed octave shift
// depends on pfn_pkg for the permutation table, gradient and lerp helpers

module pfn_octave #(
    parameter int OCTAVE = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [pfn_pkg::COORD_W-1:0]       i_bx,
    input  logic [pfn_pkg::COORD_W-1:0]       i_by,
    output logic signed [pfn_pkg::NOISE_W-1:0] o_noise
);

    // octave coordinate, wrapped at 256 cells
    logic [pfn_pkg::COORD_W-1:0] w_c [2];
    assign w_c[0] = i_bx << OCTAVE;
    assign w_c[1] = i_by << OCTAVE;

    // stage 1: first fade products, first hash level
    logic [23:0] r_s1_t  [2];
    logic [27:0] r_s1_m  [2];
    logic [23:0] r_s1_t2 [2];
    logic [15:0] r_s1_f  [2];
    logic [7:0]  r_s1_cy;
    logic [7:0]  r_s1_p0;
    logic [7:0]  r_s1_p1;

    // stage 2: fade polynomial, second hash level
    logic [27:0] r_s2_p  [2];
    logic [23:0] r_s2_t3 [2];
    logic [15:0] r_s2_f  [2];
    logic [7:0]  r_s2_ha;
    logic [7:0]  r_s2_ha1;
    logic [7:0]  r_s2_hb;
    logic [7:0]  r_s2_hb1;

    // stage 3: fade values, corner hashes
    logic [pfn_pkg::FADE_W-1:0] r_s3_fade [2];
    logic [15:0] r_s3_f  [2];
    logic [3:0]  r_s3_h  [4];

    // stage 4: corner gradients
    logic signed [pfn_pkg::NOISE_W-1:0] r_s4_g [4];
    logic [pfn_pkg::FADE_W-1:0] r_s4_u;
    logic [pfn_pkg::FADE_W-1:0] r_s4_v;

    // stage 5: lerps along x
    logic signed [pfn_pkg::NOISE_W-1:0] r_s5_l0;
    logic signed [pfn_pkg::NOISE_W-1:0] r_s5_l1;
    logic [pfn_pkg::FADE_W-1:0] r_s5_v;

    // stage 6: lerp along y
    logic signed [pfn_pkg::NOISE_W-1:0] r_s6_nz;

    logic [23:0] w_t   [2];
    logic [27:0] w_k   [2];
    logic [51:0] w_tk  [2];
    logic [47:0] w_tt  [2];
    logic [47:0] w_t3  [2];
    logic [51:0] w_f   [2];
    logic [7:0]  w_a;
    logic [7:0]  w_b;
    logic signed [17:0] w_x0;
    logic signed [17:0] w_x1;
    logic signed [17:0] w_y0;
    logic signed [17:0] w_y1;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_t[a]  = w_c[a][39:16];
            w_k[a]  = pfn_pkg::FADE_C15 - (28'({w_t[a], 2'b00}) + 28'({w_t[a], 1'b0}));
            w_tk[a] = 52'(w_t[a]) * 52'(w_k[a]);
            w_tt[a] = 48'(w_t[a]) * 48'(w_t[a]);
            w_t3[a] = 48'(r_s1_t2[a]) * 48'(r_s1_t[a]);
            w_f[a]  = 52'(r_s2_t3[a]) * 52'(r_s2_p[a]);
        end
        w_a  = r_s1_p0 + r_s1_cy;
        w_b  = r_s1_p1 + r_s1_cy;
        w_x0 = $signed({2'b00, r_s3_f[0]});
        w_x1 = w_x0 - pfn_pkg::ONE_Q16;
        w_y0 = $signed({2'b00, r_s3_f[1]});
        w_y1 = w_y0 - pfn_pkg::ONE_Q16;
    end

    // pipeline registers, frozen together when the stream stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 2; a++) begin
                r_s1_t[a]    <= w_t[a];
                r_s1_m[a]    <= w_tk[a][51:24];
                r_s1_t2[a]   <= w_tt[a][47:24];
                r_s1_f[a]    <= w_c[a][39:24];
                r_s2_p[a]    <= pfn_pkg::FADE_C10 - r_s1_m[a];
                r_s2_t3[a]   <= w_t3[a][47:24];
                r_s2_f[a]    <= r_s1_f[a];
                r_s3_fade[a] <= w_f[a][48:32];
                r_s3_f[a]    <= r_s2_f[a];
            end
            r_s1_cy  <= w_c[1][47:40];
            r_s1_p0  <= pfn_pkg::PERM[w_c[0][47:40]];
            r_s1_p1  <= pfn_pkg::PERM[8'(w_c[0][47:40] + 8'd1)];
            r_s2_ha  <= pfn_pkg::PERM[w_a];
            r_s2_ha1 <= pfn_pkg::PERM[8'(w_a + 8'd1)];
            r_s2_hb  <= pfn_pkg::PERM[w_b];
            r_s2_hb1 <= pfn_pkg::PERM[8'(w_b + 8'd1)];
            r_s3_h[0] <= pfn_pkg::PERM[8'(r_s2_ha  + 8'd1)][3:0];
            r_s3_h[1] <= pfn_pkg::PERM[8'(r_s2_hb  + 8'd1)][3:0];
            r_s3_h[2] <= pfn_pkg::PERM[8'(r_s2_ha1 + 8'd1)][3:0];
            r_s3_h[3] <= pfn_pkg::PERM[8'(r_s2_hb1 + 8'd1)][3:0];
            r_s4_g[0] <= pfn_pkg::grad2(r_s3_h[0], w_x0, w_y0);
            r_s4_g[1] <= pfn_pkg::grad2(r_s3_h[1], w_x1, w_y0);
            r_s4_g[2] <= pfn_pkg::grad2(r_s3_h[2], w_x0, w_y1);
            r_s4_g[3] <= pfn_pkg::grad2(r_s3_h[3], w_x1, w_y1);
            r_s4_u    <= r_s3_fade[0];
            r_s4_v    <= r_s3_fade[1];
            r_s5_l0   <= pfn_pkg::lerp_q16(r_s4_u, r_s4_g[0], r_s4_g[1]);
            r_s5_l1   <= pfn_pkg::lerp_q16(r_s4_u, r_s4_g[2], r_s4_g[3]);
            r_s5_v    <= r_s4_v;
            r_s6_nz   <= pfn_pkg::lerp_q16(r_s5_v, r_s5_l0, r_s5_l1);
        end
    end

    assign o_noise = r_s6_nz;

endmodule

// ----- hw/rtl/perlin_fbm_noise_pixel.sv -----
// fbm noise pixel block: up to MAX_OCTAVES parallel octave pipelines, sum and byte mapping
// depends on pfn_pkg and pfn_octave
// throughput: one item per cycle unless the output stalls; no octave pipeline is shared
// a stall on the output freezes the pipeline only once its last stage holds an item
// reset: synchronous, active low; clears valid bits, output valid and sets octave_count to 16

module perlin_fbm_noise_pixel #(
    parameter int MAX_OCTAVES = pfn_pkg::MAX_OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    // result item
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] intensity
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NGRP  = (MAX_OCTAVES + 3) / 4;
    localparam int DEPTH = pfn_pkg::PIPE_DEPTH;
    localparam int ACC_W = pfn_pkg::ACC_W;

    // configuration register
    logic [pfn_pkg::OCT_CNT_W-1:0] r_oct_cnt;
    logic [pfn_pkg::OCT_CNT_W-1:0] w_oct_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_cnt <= pfn_pkg::OCT_CNT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == pfn_pkg::REG_OCTAVE_COUNT) begin
            r_oct_cnt <= pwdata[pfn_pkg::OCT_CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pfn_pkg::REG_OCTAVE_COUNT) ? 32'(r_oct_cnt) : '0;

    // saturate the octave count into 1..MAX_OCTAVES
    always_comb begin
        if (r_oct_cnt == '0)
            w_oct_eff = pfn_pkg::OCT_CNT_W'(1);
        else if (r_oct_cnt > pfn_pkg::OCT_CNT_W'(MAX_OCTAVES))
            w_oct_eff = pfn_pkg::OCT_CNT_W'(MAX_OCTAVES);
        else
            w_oct_eff = r_oct_cnt;
    end

    // flow control: the pipeline moves unless its last stage is blocked
    logic [DEPTH-1:0] r_vld;
    logic             r_out_vld;
    logic             w_en;

    assign w_en            = !r_vld[DEPTH-1] || !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // input register and scaled base coordinates
    logic [15:0]                 r_px;
    logic [15:0]                 r_py;
    logic [pfn_pkg::COORD_W-1:0] r_bx;
    logic [pfn_pkg::COORD_W-1:0] r_by;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= i_s_axis_tdata[15:0];
            r_py <= i_s_axis_tdata[31:16];
            r_bx <= pfn_pkg::COORD_W'(r_px) * pfn_pkg::COORD_W'(pfn_pkg::COORD_K);
            r_by <= pfn_pkg::COORD_W'(r_py) * pfn_pkg::COORD_W'(pfn_pkg::COORD_K);
        end
    end

    // one pipeline per octave
    logic signed [pfn_pkg::NOISE_W-1:0] w_nz [MAX_OCTAVES];

    for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
        pfn_octave #(
            .OCTAVE (o)
        ) u_oct (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_bx    (r_bx),
            .i_by    (r_by),
            .o_noise (w_nz[o])
        );
    end

    // weighted terms and partial sums in groups of four
    logic signed [ACC_W-1:0] w_term [MAX_OCTAVES];
    logic signed [ACC_W-1:0] w_grp  [NGRP];
    logic signed [ACC_W-1:0] r_grp  [NGRP];
    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] r_acc;

    always_comb begin
        for (int o = 0; o < MAX_OCTAVES; o++) begin
            if (pfn_pkg::OCT_CNT_W'(o) < w_oct_eff)
                w_term[o] = ACC_W'(w_nz[o]) <<< (24 - o);
            else
                w_term[o] = '0;
        end
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (4 * g + j < MAX_OCTAVES)
                    w_grp[g] = w_grp[g] + w_term[4 * g + j];
            end
        end
        w_sum = '0;
        for (int g = 0; g < NGRP; g++)
            w_sum = w_sum + r_grp[g];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int g = 0; g < NGRP; g++)
                r_grp[g] <= w_grp[g];
            r_acc <= w_sum;
        end
    end

    // map s to clamp(s*0.5+0.5)*255 and truncate
    logic signed [ACC_W-1:0] w_v;
    logic [48:0]             w_scaled;
    logic [7:0]              w_byte;
    logic [7:0]              r_out;

    always_comb begin
        w_v      = r_acc + (ACC_W'(1) <<< 40);
        w_scaled = {w_v[40:0], 8'h00} - 49'(w_v[40:0]);
        if (w_v <= 0)
            w_byte = 8'd0;
        else if (w_v >= (ACC_W'(1) <<< 41))
            w_byte = 8'd255;
        else
            w_byte = w_scaled[48:41];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && r_vld[DEPTH-1]) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[DEPTH-1]) begin
            r_out <= w_byte;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

// ----- hw/rtl/perlin_fbm_noise_pixel_checker.sv -----
// port-level checker for perlin_fbm_noise_pixel and its bind statement
// depends on pfn_pkg and the top level's ports only

module perlin_fbm_noise_pixel_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result item changed while stalled");

    // no result item right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // an empty output register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // a register write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge i_clk)
        i_rst_n && psel && penable && pwrite && pready && paddr[2] == pfn_pkg::REG_OCTAVE_COUNT
        |=> paddr[2] != pfn_pkg::REG_OCTAVE_COUNT
            || prdata == 32'($past(pwdata[pfn_pkg::OCT_CNT_W-1:0])))
        else $error("octave count readback mismatch");

endmodule

bind perlin_fbm_noise_pixel perlin_fbm_noise_pixel_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
);
